### sv/pse_pkg.sv
// Shared types, constants and the control store for the postfix stack evaluator.
// Depends on nothing; every other file but pse_ram imports it.
package pse_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int FRAC_BITS   = 16;

    localparam int WORD_W   = 32;
    localparam int COUNT_W  = 5;
    localparam int KIND_W   = 2;
    localparam int OPC_W    = 2;
    localparam int STATUS_W = 3;

    localparam int SP_W   = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int ACC_W  = 2 * WORD_W;
    localparam int DIVD_W = WORD_W + FRAC_BITS;
    localparam int DCNT_W = $clog2(DIVD_W);

    localparam int IN_DATA_W  = ((WORD_W + 7) / 8) * 8;
    localparam int IN_USER_W  = KIND_W + OPC_W;
    localparam int OUT_DATA_W = ((WORD_W + COUNT_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - WORD_W - COUNT_W;
    localparam int OUT_USER_W = STATUS_W;

    localparam int STEP_W = 5;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH   = 2'd0,
        KIND_APPLY  = 2'd1,
        KIND_FINISH = 2'd2
    } kind_t;

    typedef enum logic [OPC_W-1:0] {
        OPC_ADD = 2'd0,
        OPC_SUB = 2'd1,
        OPC_MUL = 2'd2,
        OPC_DIV = 2'd3
    } opc_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_UNDERFLOW = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_DIVZERO   = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_SATURATED = 3'd5
    } status_t;

    // Datapath actions, one per control word.
    typedef enum logic [4:0] {
        U_NOP,
        U_FETCH,
        U_RD_TOP,
        U_CAP_A,
        U_RD_SEC,
        U_CAP_B,
        U_RESULT_TOP,
        U_PUSH,
        U_POP,
        U_ADDSUB,
        U_MUL,
        U_MSCALE,
        U_DIV_INIT,
        U_DIV_STEP,
        U_DIV_SIGN,
        U_WRITEBACK,
        U_EMIT
    } uop_t;

    // Jump conditions; when false the step counter advances by one.
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_IN,
        C_PUSH,
        C_FIN,
        C_APPLY,
        C_FULL,
        C_EMPTY,
        C_LT2,
        C_DIV,
        C_MUL,
        C_RZERO,
        C_DIV_BUSY,
        C_OUT_BUSY
    } cond_t;

    typedef logic [STEP_W-1:0] step_t;

    typedef struct packed {
        uop_t    uop;
        cond_t   cond;
        status_t st;
        step_t   target;
    } ctrl_word_t;

    typedef struct packed {
        logic in_valid;
        logic is_push;
        logic is_finish;
        logic is_apply;
        logic is_div;
        logic is_mul;
        logic full;
        logic empty;
        logic lt2;
        logic rzero;
        logic div_busy;
        logic out_busy;
    } dp_flags_t;

    // Entry points of the program.
    localparam step_t S_FETCH     = 5'd0;
    localparam step_t S_PUSH      = 5'd6;
    localparam step_t S_OVF       = 5'd8;
    localparam step_t S_FIN       = 5'd9;
    localparam step_t S_FIN_EMPTY = 5'd11;
    localparam step_t S_OPER      = 5'd12;
    localparam step_t S_MUL       = 5'd17;
    localparam step_t S_DIV       = 5'd19;
    localparam step_t S_DIV_LOOP  = 5'd21;
    localparam step_t S_WB        = 5'd23;
    localparam step_t S_EMIT      = 5'd24;
    localparam step_t S_DZ        = 5'd26;
    localparam step_t S_UNF       = 5'd27;

    function automatic ctrl_word_t cw(uop_t u, cond_t c, status_t s, step_t t);
        ctrl_word_t w;
        w.uop    = u;
        w.cond   = c;
        w.st     = s;
        w.target = t;
        return w;
    endfunction

    // Control store.
    function automatic ctrl_word_t ucode(step_t pc);
        ctrl_word_t w;
        case (pc)
            5'd0:        w = cw(U_FETCH,      C_NO_IN,    ST_OK,        S_FETCH);
            5'd1:        w = cw(U_RD_TOP,     C_NEVER,    ST_OK,        S_FETCH);
            5'd2:        w = cw(U_CAP_A,      C_PUSH,     ST_OK,        S_PUSH);
            5'd3:        w = cw(U_NOP,        C_FIN,      ST_OK,        S_FIN);
            5'd4:        w = cw(U_NOP,        C_APPLY,    ST_OK,        S_OPER);
            5'd5:        w = cw(U_RESULT_TOP, C_ALWAYS,   ST_OK,        S_EMIT);
            5'd6:        w = cw(U_NOP,        C_FULL,     ST_OK,        S_OVF);
            5'd7:        w = cw(U_PUSH,       C_ALWAYS,   ST_OK,        S_EMIT);
            5'd8:        w = cw(U_RESULT_TOP, C_ALWAYS,   ST_OVERFLOW,  S_EMIT);
            5'd9:        w = cw(U_NOP,        C_EMPTY,    ST_OK,        S_FIN_EMPTY);
            5'd10:       w = cw(U_POP,        C_ALWAYS,   ST_OK,        S_EMIT);
            5'd11:       w = cw(U_RESULT_TOP, C_ALWAYS,   ST_EMPTY,     S_EMIT);
            5'd12:       w = cw(U_NOP,        C_LT2,      ST_OK,        S_UNF);
            5'd13:       w = cw(U_RD_SEC,     C_NEVER,    ST_OK,        S_FETCH);
            5'd14:       w = cw(U_CAP_B,      C_DIV,      ST_OK,        S_DIV);
            5'd15:       w = cw(U_NOP,        C_MUL,      ST_OK,        S_MUL);
            5'd16:       w = cw(U_ADDSUB,     C_ALWAYS,   ST_OK,        S_WB);
            5'd17:       w = cw(U_MUL,        C_NEVER,    ST_OK,        S_FETCH);
            5'd18:       w = cw(U_MSCALE,     C_ALWAYS,   ST_OK,        S_WB);
            5'd19:       w = cw(U_NOP,        C_RZERO,    ST_OK,        S_DZ);
            5'd20:       w = cw(U_DIV_INIT,   C_NEVER,    ST_OK,        S_FETCH);
            5'd21:       w = cw(U_DIV_STEP,   C_DIV_BUSY, ST_OK,        S_DIV_LOOP);
            5'd22:       w = cw(U_DIV_SIGN,   C_NEVER,    ST_OK,        S_FETCH);
            5'd23:       w = cw(U_WRITEBACK,  C_NEVER,    ST_OK,        S_FETCH);
            5'd24:       w = cw(U_EMIT,       C_OUT_BUSY, ST_OK,        S_EMIT);
            5'd25:       w = cw(U_NOP,        C_ALWAYS,   ST_OK,        S_FETCH);
            5'd26:       w = cw(U_RESULT_TOP, C_ALWAYS,   ST_DIVZERO,   S_EMIT);
            5'd27:       w = cw(U_RESULT_TOP, C_ALWAYS,   ST_UNDERFLOW, S_EMIT);
            default:     w = cw(U_NOP,        C_ALWAYS,   ST_OK,        S_FETCH);
        endcase
        return w;
    endfunction

endpackage

### sv/postfix_stack_evaluator.sv
// Postfix evaluator over a 16-entry Q16.16 stack, run by a microprogram.
// Divide produces 48 quotient bits at one per cycle. Tokens are taken one at a time: the next
// token is accepted only after the previous result has been loaded into the output register.
// Reset empties the stack and clears the result valid flag; stack contents are not cleared.
module postfix_stack_evaluator
    import pse_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // operand_value
    input  logic [IN_USER_W-1:0]  s_axis_tuser,   // kind, op_code
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // top_value, stack_count, zero pad
    output logic [OUT_USER_W-1:0] m_axis_tuser    // status
);

    ctrl_word_t         ctrl;
    dp_flags_t          flags;
    logic [WORD_W-1:0]  out_value;
    logic [COUNT_W-1:0] out_count;
    status_t            out_status;

    pse_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    pse_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .flags      (flags),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_kind    (s_axis_tuser[KIND_W-1:0]),
        .in_opc     (s_axis_tuser[KIND_W+OPC_W-1:KIND_W]),
        .in_operand (s_axis_tdata[WORD_W-1:0]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_value  (out_value),
        .out_count  (out_count),
        .out_status (out_status)
    );

    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_count, out_value};
    assign m_axis_tuser = out_status;

endmodule

### sv/pse_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/pse_seq.sv
// Microprogram sequencer: step counter, control store lookup and conditional jumps.
// Depends on pse_pkg for the control word, flag struct and program.
module pse_seq
    import pse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_flags_t  flags,
    output ctrl_word_t ctrl
);

    step_t pc_reg;
    step_t pc_next;
    logic  take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= S_FETCH;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    always_comb
    begin
        ctrl = ucode(pc_reg);
        case (ctrl.cond)
            C_NEVER:    take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_NO_IN:    take = !flags.in_valid;
            C_PUSH:     take = flags.is_push;
            C_FIN:      take = flags.is_finish;
            C_APPLY:    take = flags.is_apply;
            C_FULL:     take = flags.full;
            C_EMPTY:    take = flags.empty;
            C_LT2:      take = flags.lt2;
            C_DIV:      take = flags.is_div;
            C_MUL:      take = flags.is_mul;
            C_RZERO:    take = flags.rzero;
            C_DIV_BUSY: take = flags.div_busy;
            C_OUT_BUSY: take = flags.out_busy;
            default:    take = 1'b0;
        endcase
        pc_next = take ? ctrl.target : pc_reg + 1'b1;
    end

endmodule

### sv/pse_dp.sv
// Datapath: stack pointer, operand registers, arithmetic, divider and result register.
// Depends on pse_pkg and instantiates pse_ram for the operand stack.
module pse_dp
    import pse_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctrl_word_t           ctrl,
    output dp_flags_t            flags,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [KIND_W-1:0]    in_kind,
    input  logic [OPC_W-1:0]     in_opc,
    input  logic [WORD_W-1:0]    in_operand,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [WORD_W-1:0]    out_value,
    output logic [COUNT_W-1:0]   out_count,
    output status_t              out_status
);

    // Control state.
    logic [SP_W-1:0] sp_reg, sp_next;
    logic            out_valid_reg, out_valid_next;

    // Payload state.
    kind_t                      kind_reg, kind_next;
    opc_t                       opc_reg, opc_next;
    logic [WORD_W-1:0]          operand_reg, operand_next;
    logic signed [WORD_W-1:0]   a_reg, a_next;
    logic signed [WORD_W-1:0]   b_reg, b_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic [WORD_W-1:0]          rem_reg, rem_next;
    logic [DIVD_W-1:0]          quo_reg, quo_next;
    logic [WORD_W-1:0]          dvs_reg, dvs_next;
    logic [DCNT_W-1:0]          dcnt_reg, dcnt_next;
    logic                       neg_reg, neg_next;
    logic [WORD_W-1:0]          res_val_reg, res_val_next;
    status_t                    res_st_reg, res_st_next;
    logic [WORD_W-1:0]          out_value_reg, out_value_next;
    logic [COUNT_W-1:0]         out_count_reg, out_count_next;
    status_t                    out_status_reg, out_status_next;

    // Stack memory port.
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    logic [SP_W-1:0]          sp_m1, sp_m2;
    logic [WORD_W-1:0]        cur_top;
    logic signed [ACC_W-1:0]  prod;
    logic signed [ACC_W-1:0]  round_add;
    logic signed [ACC_W-1:0]  rounded;
    logic [WORD_W-1:0]        a_mag, b_mag;
    logic [WORD_W:0]          rem_sh;
    logic [WORD_W+1:0]        diff;
    logic                     qbit;
    logic [ACC_W-1:0]         q_ext;
    logic                     sat;
    logic [WORD_W-1:0]        clamped;
    logic                     out_busy;

    pse_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sp_reg        <= sp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        opc_reg        <= opc_next;
        operand_reg    <= operand_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        acc_reg        <= acc_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        dvs_reg        <= dvs_next;
        dcnt_reg       <= dcnt_next;
        neg_reg        <= neg_next;
        res_val_reg    <= res_val_next;
        res_st_reg     <= res_st_next;
        out_value_reg  <= out_value_next;
        out_count_reg  <= out_count_next;
        out_status_reg <= out_status_next;
    end

    // Shared combinational terms.
    always_comb
    begin
        sp_m1    = sp_reg - 1'b1;
        sp_m2    = sp_reg - SP_W'(2);
        cur_top  = (sp_reg == '0) ? '0 : a_reg;
        out_busy = out_valid_reg && !out_ready;

        prod      = ACC_W'(b_reg) * ACC_W'(a_reg);
        // Truncation toward zero: bias negative products before the arithmetic shift.
        round_add = acc_reg[ACC_W-1] ? ACC_W'((64'd1 << FRAC_BITS) - 64'd1) : '0;
        rounded   = acc_reg + round_add;

        a_mag = a_reg[WORD_W-1] ? (~a_reg + 1'b1) : a_reg;
        b_mag = b_reg[WORD_W-1] ? (~b_reg + 1'b1) : b_reg;

        rem_sh = {rem_reg, quo_reg[DIVD_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, dvs_reg};
        qbit   = !diff[WORD_W+1];
        q_ext  = ACC_W'(quo_reg);

        sat = !((&acc_reg[ACC_W-1:WORD_W-1]) || !(|acc_reg[ACC_W-1:WORD_W-1]));
        if (!sat)
        begin
            clamped = acc_reg[WORD_W-1:0];
        end
        else if (acc_reg[ACC_W-1])
        begin
            clamped = {1'b1, {(WORD_W-1){1'b0}}};
        end
        else
        begin
            clamped = {1'b0, {(WORD_W-1){1'b1}}};
        end
    end

    // Action decode.
    always_comb
    begin
        sp_next         = sp_reg;
        kind_next       = kind_reg;
        opc_next        = opc_reg;
        operand_next    = operand_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        acc_next        = acc_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        dvs_next        = dvs_reg;
        dcnt_next       = dcnt_reg;
        neg_next        = neg_reg;
        res_val_next    = res_val_reg;
        res_st_next     = res_st_reg;
        out_value_next  = out_value_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        ram_we    = 1'b0;
        ram_waddr = sp_reg[ADDR_W-1:0];
        ram_wdata = operand_reg;
        ram_re    = 1'b0;
        ram_raddr = sp_m1[ADDR_W-1:0];

        case (ctrl.uop)
            U_FETCH:
            begin
                if (in_valid)
                begin
                    kind_next    = kind_t'(in_kind);
                    opc_next     = opc_t'(in_opc);
                    operand_next = in_operand;
                end
            end
            U_RD_TOP:
            begin
                ram_re    = 1'b1;
                ram_raddr = sp_m1[ADDR_W-1:0];
            end
            U_CAP_A:
            begin
                a_next = ram_rdata;
            end
            U_RD_SEC:
            begin
                ram_re    = 1'b1;
                ram_raddr = sp_m2[ADDR_W-1:0];
            end
            U_CAP_B:
            begin
                b_next = ram_rdata;
            end
            U_RESULT_TOP:
            begin
                res_val_next = cur_top;
                res_st_next  = ctrl.st;
            end
            U_PUSH:
            begin
                ram_we       = 1'b1;
                ram_waddr    = sp_reg[ADDR_W-1:0];
                ram_wdata    = operand_reg;
                sp_next      = sp_reg + 1'b1;
                res_val_next = operand_reg;
                res_st_next  = ST_OK;
            end
            U_POP:
            begin
                sp_next      = sp_m1;
                res_val_next = a_reg;
                res_st_next  = ST_OK;
            end
            U_ADDSUB:
            begin
                if (opc_reg == OPC_SUB)
                begin
                    acc_next = ACC_W'(b_reg) - ACC_W'(a_reg);
                end
                else
                begin
                    acc_next = ACC_W'(b_reg) + ACC_W'(a_reg);
                end
            end
            U_MUL:
            begin
                acc_next = prod;
            end
            U_MSCALE:
            begin
                acc_next = rounded >>> FRAC_BITS;
            end
            U_DIV_INIT:
            begin
                rem_next  = '0;
                quo_next  = DIVD_W'(b_mag) << FRAC_BITS;
                dvs_next  = a_mag;
                dcnt_next = '0;
                neg_next  = a_reg[WORD_W-1] ^ b_reg[WORD_W-1];
            end
            U_DIV_STEP:
            begin
                // Restoring division, one quotient bit per cycle.
                rem_next  = qbit ? diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
                quo_next  = {quo_reg[DIVD_W-2:0], qbit};
                dcnt_next = dcnt_reg + 1'b1;
            end
            U_DIV_SIGN:
            begin
                acc_next = neg_reg ? -$signed(q_ext) : $signed(q_ext);
            end
            U_WRITEBACK:
            begin
                ram_we       = 1'b1;
                ram_waddr    = sp_m2[ADDR_W-1:0];
                ram_wdata    = clamped;
                sp_next      = sp_m1;
                res_val_next = clamped;
                res_st_next  = sat ? ST_SATURATED : ST_OK;
            end
            U_EMIT:
            begin
                if (!out_busy)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = res_val_reg;
                    out_count_next  = COUNT_W'(sp_reg);
                    out_status_next = res_st_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        flags.in_valid  = in_valid;
        flags.is_push   = (kind_reg == KIND_PUSH);
        flags.is_finish = (kind_reg == KIND_FINISH);
        flags.is_apply  = (kind_reg == KIND_APPLY);
        flags.is_div    = (opc_reg == OPC_DIV);
        flags.is_mul    = (opc_reg == OPC_MUL);
        flags.full      = (sp_reg >= SP_W'(STACK_DEPTH));
        flags.empty     = (sp_reg == '0);
        flags.lt2       = (sp_reg < SP_W'(2));
        flags.rzero     = (a_reg == '0);
        flags.div_busy  = (dcnt_reg != DCNT_W'(DIVD_W - 1));
        flags.out_busy  = out_busy;
    end

    assign in_ready   = (ctrl.uop == U_FETCH);
    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_count  = out_count_reg;
    assign out_status = out_status_reg;

endmodule

### dv/testbench.sv
// Self-checking testbench for the postfix stack evaluator: a directed table, then random
// expressions under changing backpressure, checked against an in-bench evaluator or, for
// table rows with numbers of their own, against those. Depends on pse_pkg and postfix_stack_evaluator.
module testbench
    import pse_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam int RANDOM_ITEMS = 1600;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 1500000;

    typedef struct packed {
        logic [WORD_W-1:0]  top;
        logic [COUNT_W-1:0] count;
        status_t            status;
    } eval_result_t;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] value;
        opc_t              op;
        int                reps;
        bit                typed;
        eval_result_t      want;
    } token_row_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;

    logic signed [WORD_W-1:0] shadow_stack [STACK_DEPTH];
    int                       shadow_depth = 0;
    eval_result_t             results_due [$];
    token_row_t               token_table [$];

    int  mismatch_count = 0;
    int  tokens_sent    = 0;
    int  cycle_count    = 0;
    int  tx_idle_pct    = 33;
    int  rx_idle_pct    = 77;
    logic hold_rx       = 1'b0;

    postfix_stack_evaluator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [WORD_W-1:0] top_of_stack();
        if (shadow_depth == 0)
            return '0;
        return shadow_stack[shadow_depth - 1];
    endfunction

    // Evaluates one token against the shadow stack and returns the result it must produce.
    function automatic eval_result_t evaluate_token(logic [KIND_W-1:0] kind,
                                                    logic [WORD_W-1:0] value, opc_t op);
        eval_result_t res;
        longint lhs;
        longint rhs;
        longint wide;
        longint scale;
        scale = longint'(1) << FRAC_BITS;
        res.status = ST_OK;
        case (kind)
            KIND_PUSH:
            begin
                if (shadow_depth >= STACK_DEPTH)
                    res.status = ST_OVERFLOW;
                else
                begin
                    shadow_stack[shadow_depth] = value;
                    shadow_depth++;
                end
                res.top = top_of_stack();
            end
            KIND_APPLY:
            begin
                res.top = top_of_stack();
                if (shadow_depth < 2)
                    res.status = ST_UNDERFLOW;
                else
                begin
                    rhs = longint'(shadow_stack[shadow_depth - 1]);
                    lhs = longint'(shadow_stack[shadow_depth - 2]);
                    case (op)
                        OPC_ADD: wide = lhs + rhs;
                        OPC_SUB: wide = lhs - rhs;
                        OPC_MUL: wide = (lhs * rhs) / scale;
                        default: wide = (rhs == 0) ? 0 : (lhs * scale) / rhs;
                    endcase
                    if (op == OPC_DIV && rhs == 0)
                        res.status = ST_DIVZERO;
                    else
                    begin
                        if (wide > longint'(32'sh7fff_ffff))
                        begin
                            wide = longint'(32'sh7fff_ffff);
                            res.status = ST_SATURATED;
                        end
                        else if (wide < longint'(32'sh8000_0000))
                        begin
                            wide = longint'(32'sh8000_0000);
                            res.status = ST_SATURATED;
                        end
                        shadow_depth--;
                        shadow_stack[shadow_depth - 1] = wide[WORD_W-1:0];
                        res.top = wide[WORD_W-1:0];
                    end
                end
            end
            KIND_FINISH:
            begin
                if (shadow_depth == 0)
                begin
                    res.top = '0;
                    res.status = ST_EMPTY;
                end
                else
                begin
                    res.top = shadow_stack[shadow_depth - 1];
                    shadow_depth--;
                end
            end
            default: res.top = top_of_stack();
        endcase
        res.count = shadow_depth[COUNT_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    task automatic check_result();
        eval_result_t want;
        if (results_due.size() == 0)
            report_mismatch("unexpected result transaction",
                            longint'(m_axis_tdata[WORD_W-1:0]), longint'(0));
        else
        begin
            want = results_due.pop_front();
            if (m_axis_tdata[WORD_W-1:0] !== want.top)
                report_mismatch("top_value", longint'(m_axis_tdata[WORD_W-1:0]),
                                longint'(want.top));
            if (m_axis_tdata[WORD_W +: COUNT_W] !== want.count)
                report_mismatch("stack_count", longint'(m_axis_tdata[WORD_W +: COUNT_W]),
                                longint'(want.count));
            if (m_axis_tuser !== want.status)
                report_mismatch("status", longint'(m_axis_tuser), longint'(want.status));
        end
    endtask

    // Result side: check every accepted transaction, then pick the next ready level.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_result();
        m_axis_tready <= !hold_rx && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    task automatic offer_token(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] value,
                               input opc_t op);
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < tx_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= {op, kind};
        do
            @(posedge clk);
        while (!s_axis_tready);
        tokens_sent++;
        results_due.push_back(evaluate_token(kind, value, op));
    endtask

    task automatic pause_until_drained();
        s_axis_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [WORD_W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 32'h7fff_ffff;
            2:       return 32'h8000_0000;
            3, 4, 5: return $urandom;
            default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
        endcase
    endfunction

    function automatic opc_t pick_op();
        return opc_t'($urandom_range(0, 3));
    endfunction

    // Mostly complete expressions with random operands and operators; the rest is noise
    // and the occasional burst that runs the stack into overflow and back to empty.
    task automatic random_step();
        int pick;
        int pushes_left;
        int on_stack;
        pick = $urandom_range(0, 99);
        if (pick < 3)
        begin
            repeat (STACK_DEPTH + 2)
                offer_token(KIND_PUSH, pick_operand(), pick_op());
            repeat (STACK_DEPTH + 2)
                offer_token(KIND_FINISH, pick_operand(), pick_op());
        end
        else if (pick < 15)
            offer_token(KIND_W'($urandom_range(0, 3)), pick_operand(), pick_op());
        else
        begin
            pushes_left = $urandom_range(1, 6);
            on_stack = 0;
            while (pushes_left > 0 || on_stack > 1)
            begin
                if (on_stack >= 2 && (pushes_left == 0 || $urandom_range(0, 1) == 1))
                begin
                    offer_token(KIND_APPLY, pick_operand(), pick_op());
                    on_stack--;
                end
                else
                begin
                    offer_token(KIND_PUSH, pick_operand(), pick_op());
                    on_stack++;
                    pushes_left--;
                end
            end
            if (shadow_depth > 8 || $urandom_range(0, 99) < 85)
                offer_token(KIND_FINISH, pick_operand(), pick_op());
        end
    endtask

    function automatic token_row_t make_row(logic [KIND_W-1:0] kind, logic [WORD_W-1:0] value,
                                            opc_t op, int reps, bit typed,
                                            logic [WORD_W-1:0] top, logic [COUNT_W-1:0] count,
                                            status_t status);
        token_row_t r;
        r.kind  = kind;
        r.value = value;
        r.op    = op;
        r.reps  = reps;
        r.typed = typed;
        r.want  = '{top, count, status};
        return r;
    endfunction

    initial
    begin
        int phase_end;
        token_row_t row;

        // Empty stack, saturation at both ends, divide by zero, full stack, spare kind.
        token_table.push_back(make_row(KIND_FINISH, 32'h0, OPC_ADD, 1, 1, 32'h0, 0, ST_EMPTY));
        token_table.push_back(make_row(KIND_APPLY, 32'h0, OPC_ADD, 1, 1, 32'h0, 0,
                                       ST_UNDERFLOW));
        token_table.push_back(make_row(KIND_SPARE, 32'hffff_ffff, OPC_DIV, 1, 1, 32'h0, 0,
                                       ST_OK));
        token_table.push_back(make_row(KIND_PUSH, 32'h7fff_ffff, OPC_ADD, 1, 1, 32'h7fff_ffff,
                                       1, ST_OK));
        token_table.push_back(make_row(KIND_APPLY, 32'h0, OPC_MUL, 1, 1, 32'h7fff_ffff, 1,
                                       ST_UNDERFLOW));
        token_table.push_back(make_row(KIND_PUSH, 32'h7fff_ffff, OPC_ADD, 1, 1, 32'h7fff_ffff,
                                       2, ST_OK));
        token_table.push_back(make_row(KIND_APPLY, 32'h0, OPC_ADD, 1, 1, 32'h7fff_ffff, 1,
                                       ST_SATURATED));
        token_table.push_back(make_row(KIND_PUSH, 32'h8000_0000, OPC_ADD, 1, 1, 32'h8000_0000,
                                       2, ST_OK));
        token_table.push_back(make_row(KIND_APPLY, 32'h0, OPC_SUB, 1, 1, 32'h7fff_ffff, 1,
                                       ST_SATURATED));
        token_table.push_back(make_row(KIND_PUSH, 32'h0, OPC_ADD, 1, 1, 32'h0, 2, ST_OK));
        token_table.push_back(make_row(KIND_APPLY, 32'h0, OPC_DIV, 1, 1, 32'h0, 2,
                                       ST_DIVZERO));
        token_table.push_back(make_row(KIND_FINISH, 32'h0, OPC_ADD, 1, 1, 32'h0, 1, ST_OK));
        token_table.push_back(make_row(KIND_PUSH, 32'h8000_0000, OPC_ADD, 1, 1, 32'h8000_0000,
                                       2, ST_OK));
        token_table.push_back(make_row(KIND_APPLY, 32'h0, OPC_MUL, 1, 1, 32'h8000_0000, 1,
                                       ST_SATURATED));
        token_table.push_back(make_row(KIND_PUSH, 32'h0001_0000, OPC_ADD, 1, 1, 32'h0001_0000,
                                       2, ST_OK));
        token_table.push_back(make_row(KIND_APPLY, 32'h0, OPC_DIV, 1, 1, 32'h8000_0000, 1,
                                       ST_OK));
        token_table.push_back(make_row(KIND_PUSH, 32'hffff_ffff, OPC_ADD, 1, 0, 0, 0, ST_OK));
        token_table.push_back(make_row(KIND_APPLY, 32'h0, OPC_DIV, 1, 1, 32'h7fff_ffff, 1,
                                       ST_SATURATED));
        token_table.push_back(make_row(KIND_PUSH, 32'h0000_8000, OPC_ADD, 1, 0, 0, 0, ST_OK));
        token_table.push_back(make_row(KIND_APPLY, 32'h0, OPC_MUL, 1, 0, 0, 0, ST_OK));
        token_table.push_back(make_row(KIND_PUSH, 32'hfffd_0000, OPC_ADD, 1, 0, 0, 0, ST_OK));
        token_table.push_back(make_row(KIND_APPLY, 32'h0, OPC_SUB, 1, 0, 0, 0, ST_OK));
        token_table.push_back(make_row(KIND_PUSH, 32'h5a5a_a5a5, OPC_ADD, STACK_DEPTH + 1, 0,
                                       0, 0, ST_OK));
        token_table.push_back(make_row(KIND_SPARE, 32'h0, OPC_ADD, 1, 0, 0, 0, ST_OK));
        token_table.push_back(make_row(KIND_FINISH, 32'h0, OPC_ADD, STACK_DEPTH + 1, 0, 0, 0,
                                       ST_OK));

        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (token_table[i])
        begin
            row = token_table[i];
            repeat (row.reps)
            begin
                offer_token(row.kind, row.value, row.op);
                // Rows with numbers of their own override the computed expectation.
                if (row.typed)
                    results_due[results_due.size() - 1] = row.want;
            end
        end
        pause_until_drained();

        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 77 : 0;
            rx_idle_pct = (phase == 0) ? 77 : (phase == 1) ? 33 : 0;
            if (phase == 2)
            begin
                // Starve the result side while tokens keep coming, so the input backs up.
                fork
                    begin
                        hold_rx <= 1'b1;
                        repeat (HOLD_CYCLES)
                            @(posedge clk);
                        hold_rx <= 1'b0;
                    end
                join_none
            end
            phase_end = tokens_sent + RANDOM_ITEMS / 3;
            while (tokens_sent < phase_end)
                random_step();
            pause_until_drained();
        end

        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
